@@ src/wepd_pkg.sv @@
// Package for the wheel encoder speed and PWM drive block.
// Holds the widths, request codes, register indexes and configuration struct.
// No dependencies; wepd_csr, wepd_divider and the top level import it.
`default_nettype none

package wepd_pkg;

   localparam int DIV_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic [1:0] REQ_EDGE    = 2'd0;
   localparam logic [1:0] REQ_COMMAND = 2'd1;
   localparam logic [1:0] REQ_TICK    = 2'd2;

   localparam logic [2:0] CSR_DEBOUNCE     = 3'd0;
   localparam logic [2:0] CSR_DEADTIME     = 3'd1;
   localparam logic [2:0] CSR_CMD_TIMEOUT  = 3'd2;
   localparam logic [2:0] CSR_STALL_TICKS  = 3'd3;
   localparam logic [2:0] CSR_PERIOD_MIN   = 3'd4;
   localparam logic [2:0] CSR_PERIOD_MAX   = 3'd5;
   localparam logic [2:0] CSR_VEL_NUM      = 3'd6;
   localparam logic [2:0] CSR_INVERT_DIR   = 3'd7;

   localparam logic [12:0] PWM_TOP        = 13'd6249;
   localparam logic [31:0] LEVEL_DIVISOR  = 32'd32767;
   localparam logic [19:0] VEL_MAX        = 20'd1048575;
   localparam logic [7:0]  COUNT_MAX      = 8'd255;

   typedef struct packed {
      logic [19:0] debounce_us;
      logic [19:0] deadtime_us;
      logic [26:0] command_timeout_us;
      logic [7:0]  stall_ticks;
      logic [31:0] period_min_us;
      logic [31:0] period_max_us;
      logic [31:0] velocity_numerator;
      logic        invert_direction;
   } cfg_type;

endpackage

`default_nettype wire

@@ src/wepd_req_if.sv @@
// Request channel interface: valid/ready handshake and the request item.
// Depends on nothing.
`default_nettype none

interface wepd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [31:0]        now_us;
   logic signed [15:0] command;

   modport source(output valid, req_type, now_us, command, input ready);
   modport sink(input valid, req_type, now_us, command, output ready);
endinterface

`default_nettype wire

@@ src/wepd_rsp_if.sv @@
// Response channel interface: valid/ready handshake and the result item.
// Depends on nothing.
`default_nettype none

interface wepd_rsp_if;
   logic               valid;
   logic               ready;
   logic [12:0]        pwm_level;
   logic               dir_out;
   logic signed [20:0] velocity;
   logic signed [31:0] position_ticks;

   modport source(output valid, pwm_level, dir_out, velocity, position_ticks, input ready);
   modport sink(input valid, pwm_level, dir_out, velocity, position_ticks, output ready);
endinterface

`default_nettype wire

@@ src/wepd_csr.sv @@
// Configuration register file with a plain write port.
// Depends on wepd_pkg for the register indexes and the configuration struct.
`default_nettype none

module wepd_csr
   import wepd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:    cfg_in.debounce_us        = csr_wdata[19:0];
            CSR_DEADTIME:    cfg_in.deadtime_us        = csr_wdata[19:0];
            CSR_CMD_TIMEOUT: cfg_in.command_timeout_us = csr_wdata[26:0];
            CSR_STALL_TICKS: cfg_in.stall_ticks        = csr_wdata[7:0];
            CSR_PERIOD_MIN:  cfg_in.period_min_us      = csr_wdata;
            CSR_PERIOD_MAX:  cfg_in.period_max_us      = csr_wdata;
            CSR_VEL_NUM:     cfg_in.velocity_numerator = csr_wdata;
            CSR_INVERT_DIR:  cfg_in.invert_direction   = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_us        <= 20'd7000;
         cfg_ff.deadtime_us        <= 20'd2000;
         cfg_ff.command_timeout_us <= 27'd2000000;
         cfg_ff.stall_ticks        <= 8'd50;
         cfg_ff.period_min_us      <= 32'd500;
         cfg_ff.period_max_us      <= 32'd5000000;
         cfg_ff.velocity_numerator <= 32'd428932117;
         cfg_ff.invert_direction   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/wepd_divider.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on wepd_pkg for the operand width.
`default_nettype none

module wepd_divider
   import wepd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       trial;
   logic                 fits;

   assign shifted = {rem_ff, quot_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(DIV_W - 1);
         rem_in   = '0;
         quot_in  = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
         quot_in  = {quot_ff[DIV_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      dvs_ff   <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

@@ src/wheel_encoder_speed_and_pwm_drive.sv @@
// Top level: one wheel channel with encoder debounce, velocity filter and PWM drive.
// Depends on wepd_pkg, wepd_req_if, wepd_rsp_if, wepd_csr and wepd_divider.
// An edge, command or unknown request goes from ST_EXEC to ST_FINISH, which loads its result.
// A control tick goes through ST_EXEC, ST_VEL_WAIT when the divider updates the velocity,
// ST_LVL_MUL, ST_DRIVE and ST_FINISH. The next item is accepted the cycle after the result
// is loaded. Synchronous active-high reset restores the default registers and wheel state.
`default_nettype none

module wheel_encoder_speed_and_pwm_drive
   import wepd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   wepd_req_if.sink         req_chan,
   wepd_rsp_if.source       rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_EXEC      = 6'b000010,
      ST_VEL_WAIT  = 6'b000100,
      ST_LVL_MUL   = 6'b001000,
      ST_DRIVE     = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   cfg_type cfg;

   state_type          state_ff, state_in;
   logic [1:0]         kind_ff;
   logic [31:0]        now_ff;
   logic signed [15:0] cmd_ff;

   logic [31:0]        last_edge_time_ff, last_edge_time_in;
   logic [31:0]        edge_period_ff, edge_period_in;
   logic [7:0]         pending_ff, pending_in;
   logic signed [15:0] held_ff, held_in;
   logic [31:0]        last_cmd_time_ff, last_cmd_time_in;
   logic signed [20:0] fvel_ff, fvel_in;
   logic [31:0]        position_ff, position_in;
   logic [7:0]         idle_ff, idle_in;
   logic               forward_ff, forward_in;
   logic [31:0]        rev_time_ff, rev_time_in;
   logic [12:0]        drive_level_ff, drive_level_in;
   logic               drive_dir_ff, drive_dir_in;
   logic [27:0]        prod_ff, prod_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [12:0]        rsp_level_ff;
   logic               rsp_dir_ff;
   logic signed [20:0] rsp_vel_ff;
   logic [31:0]        rsp_pos_ff;
   logic               rsp_load;

   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DIV_W-1:0]   div_divisor;
   logic               div_done;
   logic [DIV_W-1:0]   div_quotient;

   logic [31:0]        edge_diff;
   logic [31:0]        cmd_age;
   logic               timed_out;
   logic               period_ok;
   logic [7:0]         idle_next;
   logic [31:0]        pos_step;
   logic [31:0]        pos_moved;
   logic [19:0]        raw_mag;
   logic signed [20:0] raw_vel;
   logic signed [23:0] fvel_wide;
   logic signed [23:0] fvel_triple;
   logic signed [23:0] ema_sum;
   logic signed [20:0] ema_vel;
   logic signed [20:0] decay_vel;
   logic [15:0]        held_abs;
   logic [12:0]        lvl_base;
   logic [15:0]        lvl_rem;
   logic [12:0]        level;
   logic               cmd_forward;
   logic [31:0]        rev_age;
   logic               accept;

   function automatic logic signed [20:0] div4_trunc(input logic signed [23:0] v);
      logic signed [23:0] adj;
      logic signed [23:0] shr;
      adj = v + (v[23] ? 24'sd3 : 24'sd0);
      shr = adj >>> 2;
      return shr[20:0];
   endfunction

   wepd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wepd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign edge_diff   = now_ff - last_edge_time_ff;
   assign cmd_age     = now_ff - last_cmd_time_ff;
   assign timed_out   = cmd_age > {5'b0, cfg.command_timeout_us};
   assign period_ok   = (edge_period_ff > cfg.period_min_us) &&
                        (edge_period_ff < cfg.period_max_us);
   assign idle_next   = (idle_ff == COUNT_MAX) ? idle_ff : idle_ff + 8'd1;
   assign pos_step    = {24'b0, pending_ff};
   assign pos_moved   = forward_ff ? position_ff + pos_step : position_ff - pos_step;

   assign raw_mag     = (div_quotient > {12'b0, VEL_MAX}) ? VEL_MAX : div_quotient[19:0];
   assign raw_vel     = forward_ff ? $signed({1'b0, raw_mag}) : -$signed({1'b0, raw_mag});
   assign fvel_wide   = {{3{fvel_ff[20]}}, fvel_ff};
   assign fvel_triple = fvel_wide + (fvel_wide <<< 1);
   assign ema_sum     = {{3{raw_vel[20]}}, raw_vel} + fvel_triple;
   assign ema_vel     = div4_trunc(ema_sum);
   assign decay_vel   = div4_trunc(fvel_triple);

   assign held_abs    = held_ff[15] ? 16'(-held_ff) : held_ff;
   assign cmd_forward = !held_ff[15];
   assign rev_age     = now_ff - rev_time_ff;

   // Division by 2^15 - 1: the shifted quotient is short by at most one.
   assign lvl_base    = prod_ff[27:15];
   assign lvl_rem     = {1'b0, prod_ff[14:0]} + {3'b0, lvl_base};
   assign level       = lvl_base + {12'b0, (lvl_rem >= LEVEL_DIVISOR[15:0])};

   assign div_start    = (state_ff == ST_EXEC) && (kind_ff == REQ_TICK) &&
                         (pending_ff != 8'd0) && period_ok;
   assign div_dividend = cfg.velocity_numerator;
   assign div_divisor  = edge_period_ff;

   always_comb begin
      state_in          = state_ff;
      last_edge_time_in = last_edge_time_ff;
      edge_period_in    = edge_period_ff;
      pending_in        = pending_ff;
      held_in           = held_ff;
      last_cmd_time_in  = last_cmd_time_ff;
      fvel_in           = fvel_ff;
      position_in       = position_ff;
      idle_in           = idle_ff;
      forward_in        = forward_ff;
      rev_time_in       = rev_time_ff;
      drive_level_in    = drive_level_ff;
      drive_dir_in      = drive_dir_ff;
      prod_in           = prod_ff;
      rsp_load          = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            unique case (kind_ff)
               REQ_EDGE: begin
                  if (edge_diff > {12'b0, cfg.debounce_us}) begin
                     edge_period_in    = edge_diff;
                     last_edge_time_in = now_ff;
                     if (pending_ff != COUNT_MAX) begin
                        pending_in = pending_ff + 8'd1;
                     end
                  end
               end
               REQ_COMMAND: begin
                  held_in          = (cmd_ff == 16'sh8000) ? 16'sh8001 : cmd_ff;
                  last_cmd_time_in = now_ff;
               end
               REQ_TICK: begin
                  if (timed_out) begin
                     held_in = '0;
                  end
                  if (pending_ff != 8'd0) begin
                     if (period_ok) begin
                        state_in = ST_VEL_WAIT;
                     end else begin
                        position_in = pos_moved;
                        pending_in  = '0;
                        idle_in     = '0;
                        state_in    = ST_LVL_MUL;
                     end
                  end else begin
                     idle_in = idle_next;
                     if (idle_next > cfg.stall_ticks) begin
                        fvel_in = decay_vel;
                     end
                     state_in = ST_LVL_MUL;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_VEL_WAIT: begin
            if (div_done) begin
               fvel_in     = ema_vel;
               position_in = pos_moved;
               pending_in  = '0;
               idle_in     = '0;
               state_in    = ST_LVL_MUL;
            end
         end
         ST_LVL_MUL: begin
            prod_in  = 28'(held_abs[14:0]) * 28'(PWM_TOP);
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            state_in = ST_FINISH;
            if (level == '0) begin
               drive_level_in = '0;
               drive_dir_in   = 1'b0;
               forward_in     = cmd_forward;
            end else if (cmd_forward != forward_ff) begin
               drive_level_in = '0;
               drive_dir_in   = 1'b0;
               rev_time_in    = now_ff;
               forward_in     = cmd_forward;
            end else if (rev_age >= {12'b0, cfg.deadtime_us}) begin
               drive_dir_in   = cmd_forward ^ cfg.invert_direction;
               drive_level_in = level;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         last_edge_time_ff <= '0;
         edge_period_ff    <= '0;
         pending_ff        <= '0;
         held_ff           <= '0;
         last_cmd_time_ff  <= '0;
         fvel_ff           <= '0;
         position_ff       <= '0;
         idle_ff           <= '0;
         forward_ff        <= 1'b1;
         rev_time_ff       <= '0;
         drive_level_ff    <= '0;
         drive_dir_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         last_edge_time_ff <= last_edge_time_in;
         edge_period_ff    <= edge_period_in;
         pending_ff        <= pending_in;
         held_ff           <= held_in;
         last_cmd_time_ff  <= last_cmd_time_in;
         fvel_ff           <= fvel_in;
         position_ff       <= position_in;
         idle_ff           <= idle_in;
         forward_ff        <= forward_in;
         rev_time_ff       <= rev_time_in;
         drive_level_ff    <= drive_level_in;
         drive_dir_ff      <= drive_dir_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept) begin
         kind_ff <= req_chan.req_type;
         now_ff  <= req_chan.now_us;
         cmd_ff  <= req_chan.command;
      end
      if (rsp_load) begin
         rsp_level_ff <= drive_level_ff;
         rsp_dir_ff   <= drive_dir_ff;
         rsp_vel_ff   <= fvel_ff;
         rsp_pos_ff   <= position_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pwm_level      = rsp_level_ff;
   assign rsp_chan.dir_out        = rsp_dir_ff;
   assign rsp_chan.velocity       = rsp_vel_ff;
   assign rsp_chan.position_ticks = $signed(rsp_pos_ff);

endmodule

`default_nettype wire
